### rtl/core/mct_pkg.sv
// mct_pkg: shared types, constants and helpers of the midi clock transport core
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package mct_pkg;

    localparam int CMD_W    = 2;
    localparam int EXT_W    = 2;
    localparam int FRAMES_W = 13;
    localparam int OFF_W    = 12;
    localparam int CNT_W    = 8;
    localparam int WIDE_W   = 32;
    localparam int PLEN_W   = 16;
    localparam int POS_W    = PLEN_W + 1;
    localparam int NEV_W    = 6;
    localparam int IDX_W    = 2;
    localparam int CFGD_W   = 16;

    localparam int DEF_MAX_FRAMES  = 4096;
    localparam int DEF_QUEUE_DEPTH = 2;
    localparam int N_MAX_EV        = 33;

    localparam logic [PLEN_W-1:0] MIN_PULSE_LEN = 16'd128;

    // host commands
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

    // external transport states
    localparam logic [EXT_W-1:0] EXT_STOPPED = 2'd0;
    localparam logic [EXT_W-1:0] EXT_ROLLING = 2'd1;

    // midi realtime bytes
    localparam logic [7:0] MIDI_NONE  = 8'h00;
    localparam logic [7:0] MIDI_CLOCK = 8'hF8;
    localparam logic [7:0] MIDI_START = 8'hFA;
    localparam logic [7:0] MIDI_CONT  = 8'hFB;
    localparam logic [7:0] MIDI_STOP  = 8'hFC;

    // register indexes and reset values
    localparam logic [IDX_W-1:0] REG_PULSE_LEN = 2'd0;
    localparam logic [IDX_W-1:0] REG_PPB       = 2'd1;
    localparam logic [IDX_W-1:0] REG_BPB       = 2'd2;
    localparam logic [IDX_W-1:0] REG_FOLLOW    = 2'd3;

    localparam logic [PLEN_W-1:0] RST_PULSE_LEN = 16'd1000;
    localparam logic [CNT_W-1:0]  RST_PPB       = 8'd24;
    localparam logic [CNT_W-1:0]  RST_BPB       = 8'd4;

    typedef struct packed {
        logic [PLEN_W-1:0] pulse_len;
        logic [CNT_W-1:0]  ppb;
        logic [CNT_W-1:0]  bpb;
        logic              follow;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [FRAMES_W-1:0] frames;
        logic                running;
    } t_job;

    typedef struct packed {
        logic              has_cmd;
        logic [7:0]        cmd_byte;
        logic [OFF_W-1:0]  pos0;
        logic [NEV_W-1:0]  npulse;
        logic [OFF_W-1:0]  plen;
        logic              running;
        logic [CNT_W-1:0]  pulse_ctr;
        logic [CNT_W-1:0]  beat_ctr;
        logic [WIDE_W-1:0] bar_ctr;
        logic [WIDE_W-1:0] last_pulse;
        logic [WIDE_W-1:0] beat_pos;
    } t_snap;

    function automatic logic [7:0] cmd_byte(input logic [CMD_W-1:0] cmd);
        logic [7:0] b;
        case (cmd)
            CMD_START: b = MIDI_START;
            CMD_CONT:  b = MIDI_CONT;
            CMD_STOP:  b = MIDI_STOP;
            default:   b = MIDI_NONE;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/mct_front.sv
// mct_front: configuration registers, command gating and follow-mode override
// depends on mct_pkg; pushes one classified job per accepted buffer
`timescale 1ns / 1ps

module mct_front import mct_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [CFGD_W-1:0]   i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [FRAMES_W-1:0] i_frames,
    input  logic [EXT_W-1:0]    i_ext_state,
    output t_job                o_job,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output t_cfg                o_cfg
);

    localparam logic [FRAMES_W-1:0] FRAMES_CAP = FRAMES_W'(MAX_FRAMES);

    t_cfg             r_cfg;
    logic             r_running;
    logic [EXT_W-1:0] r_prev_ext;
    logic             n_running;
    logic [EXT_W-1:0] n_prev_ext;
    logic [CMD_W-1:0] cmd;
    logic             ext_change;
    logic             accept;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign accept      = i_valid && i_job_ready;
    assign ext_change  = r_cfg.follow && (i_ext_state != r_prev_ext);

    always_comb begin
        cmd = i_command;
        if ((cmd == CMD_START) || (cmd == CMD_CONT)) begin
            if (r_running) cmd = CMD_NONE;
        end else if (cmd == CMD_STOP) begin
            if (!r_running) cmd = CMD_NONE;
        end
        // external state change wins over the host request
        n_prev_ext = r_prev_ext;
        if (ext_change) begin
            n_prev_ext = i_ext_state;
            case (i_ext_state)
                EXT_STOPPED: cmd = CMD_STOP;
                EXT_ROLLING: cmd = CMD_START;
                default:     cmd = CMD_NONE;
            endcase
        end
        case (cmd)
            CMD_START: n_running = 1'b1;
            CMD_CONT:  n_running = 1'b1;
            CMD_STOP:  n_running = 1'b0;
            default:   n_running = r_running;
        endcase
    end

    always_comb begin
        o_job.cmd     = cmd;
        o_job.frames  = (i_frames > FRAMES_CAP) ? FRAMES_CAP : i_frames;
        o_job.running = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_len <= RST_PULSE_LEN;
            r_cfg.ppb       <= RST_PPB;
            r_cfg.bpb       <= RST_BPB;
            r_cfg.follow    <= 1'b0;
            r_running       <= 1'b0;
            r_prev_ext      <= EXT_STOPPED;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PULSE_LEN: r_cfg.pulse_len <= i_cfg_data[PLEN_W-1:0];
                    REG_PPB:       r_cfg.ppb       <= i_cfg_data[CNT_W-1:0];
                    REG_BPB:       r_cfg.bpb       <= i_cfg_data[CNT_W-1:0];
                    REG_FOLLOW:    r_cfg.follow    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_running  <= n_running;
                r_prev_ext <= n_prev_ext;
            end
        end
    end

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (o_job.cmd == CMD_START)) |=> r_running)
        else $error("transport not running after an accepted start");

    a_prev_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_cfg.follow) |=> $stable(r_prev_ext))
        else $error("external state tracked outside follow mode");

endmodule

### rtl/core/mct_queue.sv
// mct_queue: small register fifo of classified jobs between front and pulse unit
// depends on mct_pkg for the job type
`timescale 1ns / 1ps

module mct_queue import mct_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_data,
    input  logic i_valid,
    output logic o_ready,
    output t_job o_data,
    output logic o_valid,
    input  logic i_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("job queue overfilled");

endmodule

### rtl/core/mct_pulse.sv
// mct_pulse: transport counters; walks the pulse positions of one buffer, one per cycle
// depends on mct_pkg; hands a snapshot of the final status to mct_emit
`timescale 1ns / 1ps

module mct_pulse import mct_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_job  i_job,
    input  logic  i_job_valid,
    output logic  o_job_ready,
    output t_snap o_snap,
    output logic  o_snap_valid,
    input  logic  i_snap_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HAND = 2'd2;

    logic [1:0]          r_state,       n_state;
    logic [PLEN_W-1:0]   r_next_pulse,  n_next_pulse;
    logic [CNT_W-1:0]    r_pulse_ctr,   n_pulse_ctr;
    logic [CNT_W-1:0]    r_beat_ctr,    n_beat_ctr;
    logic [WIDE_W-1:0]   r_bar_ctr,     n_bar_ctr;
    logic [WIDE_W-1:0]   r_last_pulse,  n_last_pulse;
    logic [WIDE_W-1:0]   r_beat_offset, n_beat_offset;
    logic [POS_W-1:0]    r_pos,         n_pos;
    logic [OFF_W-1:0]    r_pos0,        n_pos0;
    logic [NEV_W-1:0]    r_nev,         n_nev;
    logic                r_pulsed,      n_pulsed;
    logic [FRAMES_W-1:0] r_frames,      n_frames;
    logic                r_run,         n_run;
    logic [CMD_W-1:0]    r_cmd,         n_cmd;

    logic [PLEN_W-1:0] plen;
    logic [PLEN_W-1:0] start_np;
    logic [CNT_W:0]    pc1;
    logic [CNT_W:0]    bc1;
    logic              step;
    logic              has_cmd;

    assign plen = (i_cfg.pulse_len < MIN_PULSE_LEN) ? MIN_PULSE_LEN : i_cfg.pulse_len;
    assign o_job_ready  = (r_state == S_IDLE);
    assign o_snap_valid = (r_state == S_HAND);
    assign has_cmd      = (r_cmd != CMD_NONE);
    assign pc1  = {1'b0, r_pulse_ctr} + 1'b1;
    assign bc1  = {1'b0, r_beat_ctr} + 1'b1;
    assign step = r_run && (r_pos < POS_W'(r_frames)) && (r_nev < NEV_W'(N_MAX_EV));

    always_comb begin
        n_state       = r_state;
        n_next_pulse  = r_next_pulse;
        n_pulse_ctr   = r_pulse_ctr;
        n_beat_ctr    = r_beat_ctr;
        n_bar_ctr     = r_bar_ctr;
        n_last_pulse  = r_last_pulse;
        n_beat_offset = r_beat_offset;
        n_pos         = r_pos;
        n_pos0        = r_pos0;
        n_nev         = r_nev;
        n_pulsed      = r_pulsed;
        n_frames      = r_frames;
        n_run         = r_run;
        n_cmd         = r_cmd;
        start_np      = r_next_pulse;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.cmd == CMD_START) begin
                        n_bar_ctr   = '0;
                        n_beat_ctr  = '0;
                        n_pulse_ctr = '0;
                        start_np    = '0;
                    end
                    n_next_pulse  = start_np;
                    n_beat_offset = r_beat_offset + WIDE_W'(i_job.frames);
                    n_pos         = {1'b0, start_np};
                    n_pos0        = start_np[OFF_W-1:0];
                    n_nev         = (i_job.cmd != CMD_NONE) ? NEV_W'(1) : '0;
                    n_pulsed      = 1'b0;
                    n_frames      = i_job.frames;
                    n_run         = i_job.running;
                    n_cmd         = i_job.cmd;
                    n_state       = S_RUN;
                end
            end
            S_RUN: begin
                if (step) begin
                    n_last_pulse = WIDE_W'(r_pos);
                    if (pc1 >= {1'b0, i_cfg.ppb}) begin
                        n_pulse_ctr   = '0;
                        n_beat_offset = WIDE_W'(r_pos);
                        if (bc1 >= {1'b0, i_cfg.bpb}) begin
                            n_beat_ctr = '0;
                            n_bar_ctr  = r_bar_ctr + 1'b1;
                        end else begin
                            n_beat_ctr = bc1[CNT_W-1:0];
                        end
                    end else begin
                        n_pulse_ctr = pc1[CNT_W-1:0];
                    end
                    n_nev    = r_nev + 1'b1;
                    n_pos    = r_pos + POS_W'(plen);
                    n_pulsed = 1'b1;
                end else begin
                    if (r_run) begin
                        // carry the remainder of the pulse period into the next buffer
                        n_next_pulse = (r_pos >= POS_W'(r_frames))
                                     ? PLEN_W'(r_pos - POS_W'(r_frames)) : '0;
                        if (!r_pulsed) n_last_pulse = r_last_pulse + WIDE_W'(r_frames);
                    end
                    n_state = S_HAND;
                end
            end
            S_HAND: begin
                if (i_snap_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_snap.has_cmd    = has_cmd;
        o_snap.cmd_byte   = cmd_byte(r_cmd);
        o_snap.pos0       = r_pos0;
        o_snap.npulse     = r_nev - NEV_W'(has_cmd);
        o_snap.plen       = plen[OFF_W-1:0];
        o_snap.running    = r_run;
        o_snap.pulse_ctr  = r_pulse_ctr;
        o_snap.beat_ctr   = r_beat_ctr;
        o_snap.bar_ctr    = r_bar_ctr;
        o_snap.last_pulse = r_last_pulse;
        o_snap.beat_pos   = r_beat_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_next_pulse  <= '0;
            r_pulse_ctr   <= '0;
            r_beat_ctr    <= '0;
            r_bar_ctr     <= '0;
            r_last_pulse  <= '0;
            r_beat_offset <= '0;
            r_nev         <= '0;
            r_pulsed      <= 1'b0;
            r_run         <= 1'b0;
            r_cmd         <= CMD_NONE;
        end else begin
            r_state       <= n_state;
            r_next_pulse  <= n_next_pulse;
            r_pulse_ctr   <= n_pulse_ctr;
            r_beat_ctr    <= n_beat_ctr;
            r_bar_ctr     <= n_bar_ctr;
            r_last_pulse  <= n_last_pulse;
            r_beat_offset <= n_beat_offset;
            r_nev         <= n_nev;
            r_pulsed      <= n_pulsed;
            r_run         <= n_run;
            r_cmd         <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_pos0   <= n_pos0;
        r_frames <= n_frames;
    end

    a_nev_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nev <= NEV_W'(N_MAX_EV))
        else $error("more events than a buffer can carry");

    a_hand_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !step) |=> (r_state == S_HAND))
        else $error("pulse walk finished without handing off");

endmodule

### rtl/core/mct_emit.sv
// mct_emit: output stage; plays one buffer's command and clock events to the result channel
// depends on mct_pkg; offsets of clocks are rebuilt from the first position and the period
`timescale 1ns / 1ps

module mct_emit import mct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_snap             i_snap,
    input  logic              i_snap_valid,
    output logic              o_snap_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_has_event,
    output logic [7:0]        o_midi_byte,
    output logic [OFF_W-1:0]  o_event_offset,
    output logic              o_running,
    output logic [CNT_W-1:0]  o_pulse_count,
    output logic [CNT_W-1:0]  o_beat_count,
    output logic [WIDE_W-1:0] o_bar_count,
    output logic [WIDE_W-1:0] o_last_pulse_pos,
    output logic [WIDE_W-1:0] o_beat_pos,
    output logic              o_last_of_run
);

    logic             r_active;
    logic             r_cmd_pend;
    logic [NEV_W-1:0] r_left;
    logic [OFF_W-1:0] r_epos;
    t_snap            r_snap;
    logic             last;
    logic             take;
    logic             load;
    logic             clk_pend;

    assign clk_pend = (r_left != '0);
    assign last     = r_cmd_pend ? !clk_pend : (r_left <= NEV_W'(1));
    assign take     = r_active && i_ready;
    assign o_snap_ready = !r_active || (i_ready && last);
    assign load     = i_snap_valid && o_snap_ready;

    assign o_valid          = r_active;
    assign o_has_event      = r_cmd_pend || clk_pend;
    assign o_midi_byte      = r_cmd_pend ? r_snap.cmd_byte : (clk_pend ? MIDI_CLOCK : MIDI_NONE);
    assign o_event_offset   = (!r_cmd_pend && clk_pend) ? r_epos : '0;
    assign o_running        = r_snap.running;
    assign o_pulse_count    = r_snap.pulse_ctr;
    assign o_beat_count     = r_snap.beat_ctr;
    assign o_bar_count      = r_snap.bar_ctr;
    assign o_last_pulse_pos = r_snap.last_pulse;
    assign o_beat_pos       = r_snap.beat_pos;
    assign o_last_of_run    = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_cmd_pend <= 1'b0;
            r_left     <= '0;
        end else if (load) begin
            r_active   <= 1'b1;
            r_cmd_pend <= i_snap.has_cmd;
            r_left     <= i_snap.npulse;
        end else if (take) begin
            if (last) begin
                r_active <= 1'b0;
            end else if (r_cmd_pend) begin
                r_cmd_pend <= 1'b0;
            end else begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // offsets stay below the buffer length, so 12-bit wraparound is harmless
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_snap <= i_snap;
            r_epos <= i_snap.pos0;
        end else if (take && !r_cmd_pend && clk_pend) begin
            r_epos <= r_epos + r_snap.plen;
        end
    end

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_event) |-> o_last_of_run)
        else $error("event-free result not marked last");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last && !i_snap_valid) |=> !r_active)
        else $error("output stage stayed busy after the last transaction");

endmodule

### rtl/core/midi_clock_transport_core.sv
// midi_clock_transport_core: top level of the midi beat clock generator
// depends on mct_pkg, mct_front, mct_queue, mct_pulse and mct_emit
`timescale 1ns / 1ps

// Usage: one input transaction per audio buffer (command, frames, ext_state).
// Results come out one transaction per event: an accepted start, continue or
// stop byte at offset 0 first, then one 0xF8 clock per pulse position in the
// buffer. A buffer with no event yields a single result with has_event low.
// Every result carries the transport status after the whole buffer, and
// last_of_run marks the final result of each buffer.
// Configuration writes (pulse length, pulses per beat, bar length,
// follow mode) are taken in any cycle and belong to idle periods.
// Steps: the pulse unit loads a buffer, walks its n clock pulses one per
// cycle (n is at most 33, 32 with a command), closes the walk and hands
// off, waiting while the output stage is busy. The first result is offered
// once the hand-off is taken; then one result per cycle while the receiver
// is ready. The pulse walk is the limit; a new buffer waits for the hand-off.
// A two-entry job queue lets new buffers be accepted while results stall.
// Reset (synchronous, active low) restores the register defaults and clears
// the transport to idle with all counters zero; no clearing pass is needed.
// A stalled receiver holds the current result and, once the queue fills,
// backpressures the input channel.

module midi_clock_transport_core import mct_pkg::*; #(
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [CFGD_W-1:0]   i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [FRAMES_W-1:0] i_frames,
    input  logic [EXT_W-1:0]    i_ext_state,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_has_event,
    output logic [7:0]          o_midi_byte,
    output logic [OFF_W-1:0]    o_event_offset,
    output logic                o_running,
    output logic [CNT_W-1:0]    o_pulse_count,
    output logic [CNT_W-1:0]    o_beat_count,
    output logic [WIDE_W-1:0]   o_bar_count,
    output logic [WIDE_W-1:0]   o_last_pulse_pos,
    output logic [WIDE_W-1:0]   o_beat_pos,
    output logic                o_last_of_run
);

    t_cfg  cfg;
    t_job  fr_job;
    logic  fr_valid;
    logic  fr_ready;
    t_job  q_job;
    logic  q_valid;
    logic  q_ready;
    t_snap snap;
    logic  snap_valid;
    logic  snap_ready;

    mct_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_frames    (i_frames),
        .i_ext_state (i_ext_state),
        .o_job       (fr_job),
        .o_job_valid (fr_valid),
        .i_job_ready (fr_ready),
        .o_cfg       (cfg)
    );

    mct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (fr_job),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .o_data  (q_job),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    mct_pulse u_pulse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_job        (q_job),
        .i_job_valid  (q_valid),
        .o_job_ready  (q_ready),
        .o_snap       (snap),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready)
    );

    mct_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap           (snap),
        .i_snap_valid     (snap_valid),
        .o_snap_ready     (snap_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_has_event      (o_has_event),
        .o_midi_byte      (o_midi_byte),
        .o_event_offset   (o_event_offset),
        .o_running        (o_running),
        .o_pulse_count    (o_pulse_count),
        .o_beat_count     (o_beat_count),
        .o_bar_count      (o_bar_count),
        .o_last_pulse_pos (o_last_pulse_pos),
        .o_beat_pos       (o_beat_pos),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
